### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the heading steering block.
// Expects a clock named clk and a synchronous active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/hps_pkg.sv
// Package for the heading PD steering block: widths, arctangent table,
// state encoding and the status group of the angle unit. No dependencies.
package hps_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int STEP_W       = $clog2(CORDIC_ITERS);
  localparam int PRE_SHIFT    = 16;
  // headroom for the CORDIC gain on a diagonal vector plus sign
  localparam int XW           = COORD_BITS + PRE_SHIFT + 3;
  localparam int ZW           = 32;
  localparam int GAIN_W       = 24;
  localparam int ERR_W        = 16;
  localparam int DERR_W       = ERR_W + 1;
  localparam int PROD_W       = GAIN_W + DERR_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int RND_SHIFT    = 21;
  localparam int STEER_W      = 16;
  localparam int IN_W         = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W        = 2 * STEER_W;

  localparam logic signed [ZW-1:0]     QUARTER_TURN = 32'sh4000_0000;
  localparam logic [ERR_W-1:0]         ERR_FULL     = 16'd32768;
  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 24'sd734003;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = -24'sd524;

  // register index, taken from paddr[2]
  localparam logic REG_PROP_GAIN  = 1'b0;
  localparam logic REG_DERIV_GAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_ROUND,
    ST_OUT
  } hps_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hps_cordic_status_t;

  // atan(2^-i) with pi/2 = 2^30
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'sh2000_0000;
      5'd1:    v = 32'sh12E4_051E;
      5'd2:    v = 32'sh09FB_385B;
      5'd3:    v = 32'sh0511_11D4;
      5'd4:    v = 32'sh028B_0D43;
      5'd5:    v = 32'sh0145_D7E1;
      5'd6:    v = 32'sh00A2_F61E;
      5'd7:    v = 32'sh0051_7C55;
      5'd8:    v = 32'sh0028_BE53;
      5'd9:    v = 32'sh0014_5F2F;
      5'd10:   v = 32'sh000A_2F98;
      5'd11:   v = 32'sh0005_17CC;
      5'd12:   v = 32'sh0002_8BE6;
      5'd13:   v = 32'sh0001_45F3;
      5'd14:   v = 32'sh0000_A2FA;
      5'd15:   v = 32'sh0000_517D;
      5'd16:   v = 32'sh0000_28BE;
      5'd17:   v = 32'sh0000_145F;
      5'd18:   v = 32'sh0000_0A30;
      5'd19:   v = 32'sh0000_0518;
      5'd20:   v = 32'sh0000_028C;
      5'd21:   v = 32'sh0000_0146;
      5'd22:   v = 32'sh0000_00A3;
      5'd23:   v = 32'sh0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/hps_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle rounded
// to Q1.15 of a quarter turn. Depends on hps_pkg.
module hps_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hps_pkg::COORD_BITS-1:0] mag_x,
  input  logic [hps_pkg::COORD_BITS-1:0] mag_y,
  output hps_pkg::hps_cordic_status_t   status,
  output logic [hps_pkg::ERR_W-1:0]     angle_q15
);
  import hps_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_ITERS - 1);

  logic signed [XW-1:0] x, y, x_next, y_next, xs, ys;
  logic signed [ZW-1:0] z, z_next, atan_val;
  logic [STEP_W-1:0]    cnt;
  logic                 busy, done;
  logic [ZW-2:0]        z_clamped;

  always_comb begin
    xs       = x >>> cnt;
    ys       = y >>> cnt;
    atan_val = atan_entry(5'(cnt));
    if (!y[XW-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + atan_val;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= signed'({{(XW-COORD_BITS-PRE_SHIFT){1'b0}}, mag_x, {PRE_SHIFT{1'b0}}});
      y <= signed'({{(XW-COORD_BITS-PRE_SHIFT){1'b0}}, mag_y, {PRE_SHIFT{1'b0}}});
      z <= '0;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  always_comb begin
    if (z[ZW-1]) begin
      z_clamped = '0;
    end else if (z > QUARTER_TURN) begin
      z_clamped = QUARTER_TURN[ZW-2:0];
    end else begin
      z_clamped = z[ZW-2:0];
    end
  end

  assign angle_q15   = ERR_W'((z_clamped + 31'd16384) >> 15);
  assign status.busy = busy;
  assign status.done = done;

endmodule

### hw/rtl/heading_pd_steering.sv
// Heading PD steering controller: top level with APB gain registers, the
// sequencer, one shared multiplier and the output register.
// Depends on hps_pkg, hps_cordic and assert_macros.svh.
//
//  channel  | dir | handshake           | content
//  s_*      | in  | s_tvalid/s_tready   | line end points
//  m_*      | out | m_tvalid/m_tready   | steering command, heading error, flag
//  apb      | in  | psel/penable/pwrite | prop_gain, deriv_gain
//
// An item passes through the iterative CORDIC, which performs one
// micro-rotation per cycle; an item with equal x coordinates skips the
// CORDIC and the multiplier. s_tready is high only when idle.
// The result register lets the next item in while the last result waits.
// Reset is synchronous; gains return to 0.7 and -0.0005, stored error to 0.
`include "assert_macros.svh"

module heading_pd_steering (
  input  logic                       clk,
  input  logic                       rst,
  // s_tdata: start_x, start_y, end_x, end_y
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [hps_pkg::IN_W-1:0]   s_tdata,
  // m_tdata: steering_value, heading_error
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [hps_pkg::OUT_W-1:0]  m_tdata,
  // m_tuser: straight
  output logic [0:0]                 m_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hps_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd1 << (RND_SHIFT - 1));

  hps_state_t state, state_next;
  hps_cordic_status_t cstat;

  logic signed [GAIN_W-1:0] prop_gain, deriv_gain;
  logic [ERR_W-1:0]         previous_error, err;
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0]     dx, dy;
  logic [COORD_BITS-1:0]    mag_x, mag_y;
  logic                     dx_neg, dy_neg, dy_zero, straight;
  logic                     accept, start, load_out, cfg_write;
  logic [ERR_W-1:0]         angle_q15;
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [DERR_W-1:0] mul_b, err_ext, derr;
  logic signed [PROD_W-1:0] mul_out, prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-RND_SHIFT-1:0] steer_raw;
  logic signed [ACC_W-RND_SHIFT:0]   steer_sgn;
  logic signed [STEER_W-1:0] steer_sat;
  logic signed [STEER_W-1:0] out_steer;
  logic [ERR_W-1:0]          out_heading;
  logic                      out_straight;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PROP_GAIN_RST;
      deriv_gain <= DERIV_GAIN_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PROP_GAIN:  prop_gain  <= signed'(pwdata[GAIN_W-1:0]);
        REG_DERIV_GAIN: deriv_gain <= signed'(pwdata[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PROP_GAIN:  prdata = 32'(prop_gain);
      REG_DERIV_GAIN: prdata = 32'(deriv_gain);
      default:        prdata = '0;
    endcase
  end

  // input decode
  assign sx = signed'(s_tdata[COORD_BITS-1:0]);
  assign sy = signed'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
  assign ex = signed'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
  assign ey = signed'(s_tdata[4*COORD_BITS-1:3*COORD_BITS]);
  assign dx = DW'(sx) - DW'(ex);
  assign dy = DW'(sy) - DW'(ey);
  assign mag_x = dx[DW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign mag_y = dy[DW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

  hps_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .status    (cstat),
    .angle_q15 (angle_q15)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    start      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (dx == '0) begin
            state_next = ST_OUT;
          end else begin
            start      = 1'b1;
            state_next = ST_ANGLE;
          end
        end
      end
      ST_ANGLE: begin
        if (cstat.done) begin
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // shared multiplier: proportional term, then derivative term
  assign err_ext = signed'({1'b0, err});
  assign derr    = err_ext - signed'({1'b0, previous_error});
  assign mul_a   = (state == ST_MUL_P) ? prop_gain : deriv_gain;
  assign mul_b   = (state == ST_MUL_P) ? err_ext : derr;
  assign mul_out = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_neg   <= dx[DW-1];
      dy_neg   <= dy[DW-1];
      dy_zero  <= (dy == '0);
      straight <= (dx == '0);
    end
    if (state == ST_ANGLE && cstat.done) begin
      err <= ERR_FULL - angle_q15;
    end
    case (state)
      ST_MUL_P: prod <= mul_out;
      ST_MUL_D: begin
        acc  <= ACC_W'(prod);
        prod <= mul_out;
      end
      ST_ROUND: acc <= acc + ACC_W'(prod) + RND;
      default: ;
    endcase
  end

  // round, sign and saturate
  assign steer_raw = acc[ACC_W-1:RND_SHIFT];
  always_comb begin
    if (!dy_zero && (dx_neg != dy_neg)) begin
      steer_sgn = -(ACC_W-RND_SHIFT+1)'(steer_raw);
    end else begin
      steer_sgn = (ACC_W-RND_SHIFT+1)'(steer_raw);
    end
    if (steer_sgn > (ACC_W-RND_SHIFT+1)'(32767)) begin
      steer_sat = 16'sh7FFF;
    end else if (steer_sgn < -(ACC_W-RND_SHIFT+1)'(32768)) begin
      steer_sat = -16'sh8000;
    end else begin
      steer_sat = steer_sgn[STEER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid       <= 1'b0;
      previous_error <= '0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load_out && !straight) begin
        previous_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_straight <= straight;
      out_steer    <= straight ? '0 : steer_sat;
      out_heading  <= straight ? '0 : err;
    end
  end

  assign m_tdata = {out_heading, out_steer};
  assign m_tuser = out_straight;

  `ASSERT_IMPLY(a_ready_unit_idle, s_tready, !cstat.busy, "input ready while CORDIC busy")
  `ASSERT_IMPLY(a_done_in_angle, cstat.done, state == ST_ANGLE, "CORDIC done outside angle state")
  `ASSERT_IMPLY(a_straight_zero, m_tvalid && m_tuser[0], m_tdata == '0, "straight item not zero")
  `ASSERT_IMPLY(a_err_range, m_tvalid, out_heading <= ERR_FULL, "heading error out of range")

endmodule
